FILE: hdl/mtap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtap_pkg
// types and constants shared by the title atom parser modules
// ----------------------------------------------------------------------------
package mtap_pkg;

  localparam logic [15:0] HdrBytes  = 16'd20;
  localparam logic [31:0] TagWord   = 32'h4d544454;
  localparam logic [15:0] One16     = 16'h0001;
  localparam logic [31:0] One32     = 32'h00000001;
  localparam logic [15:0] SizeBias  = 16'd10;

  // byte positions at which a header field completes
  localparam logic [15:0] PosLen    = 16'd3;
  localparam logic [15:0] PosTag    = 16'd7;
  localparam logic [15:0] PosVer    = 16'd9;
  localparam logic [15:0] PosSize   = 16'd11;
  localparam logic [15:0] PosWord   = 16'd15;
  localparam logic [15:0] PosFlag   = 16'd19;
  localparam logic [15:0] PosMax    = 16'hffff;

  localparam logic KindChar = 1'b0;
  localparam logic KindDone = 1'b1;

  localparam int unsigned RqDepth = 4;
  localparam int unsigned RqPtrW  = $clog2(RqDepth);
  localparam int unsigned RqCntW  = $clog2(RqDepth + 1);

  typedef enum logic [2:0] {
    StOk    = 3'd0,
    StLen   = 3'd1,
    StTag   = 3'd2,
    StVer   = 3'd3,
    StWord  = 3'd4,
    StFlag  = 3'd5,
    StTrunc = 3'd6
  } status_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
    logic [7:0] char_index;
    status_e    status;
    logic [7:0] title_length;
    logic       final_res;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

FILE: hdl/mtap_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtap_in_if / mtap_out_if
// valid/ready channels for atom bytes and parser results
// ----------------------------------------------------------------------------
interface mtap_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_value;
  logic [15:0] atom_length;
  logic        is_last;

  modport source (output valid, byte_value, atom_length, is_last, input ready);
  modport sink (input valid, byte_value, atom_length, is_last, output ready);
  modport monitor (input valid, ready, byte_value, atom_length, is_last);
endinterface

interface mtap_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  char_code;
  logic [7:0]  char_index;
  logic [2:0]  status;
  logic [7:0]  title_length;
  logic        final_res;

  modport source (output valid, kind, char_code, char_index, status, title_length,
                  final_res, input ready);
  modport sink (input valid, kind, char_code, char_index, status, title_length,
                final_res, output ready);
  modport monitor (input valid, ready, kind, char_code, char_index, status,
                   title_length, final_res);
endinterface

FILE: hdl/mtap_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtap_core
// header checks, title extraction and completion for one accepted byte per cycle
// ----------------------------------------------------------------------------
module mtap_core #(
  parameter int unsigned MAX_TITLE = 255
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           byte_value_i,
  input  logic [15:0]          atom_length_i,
  input  logic                 is_last_i,
  output mtap_pkg::push_t      push_o
);

  localparam logic [7:0] MaxTitleC = 8'(MAX_TITLE);

  logic [15:0]       pos_q, pos_d;
  logic [31:0]       hdr_q, hdr_d;
  logic [15:0]       wanted_q, wanted_d;
  logic [7:0]        emitted_q, emitted_d;
  mtap_pkg::status_e err_q, err_d;

  logic [31:0]       hdr_n;
  logic [15:0]       wanted_n;
  logic [7:0]        emitted_n;
  mtap_pkg::status_e err_n;
  mtap_pkg::status_e st_done;
  logic [15:0]       sz;
  logic [16:0]       pos_inc;
  logic              emit;
  logic              trunc;
  mtap_pkg::result_t res_char, res_done;

  always_comb begin
    hdr_n     = {hdr_q[23:0], byte_value_i};
    sz        = hdr_n[15:0];
    err_n     = err_q;
    wanted_n  = wanted_q;
    emitted_n = emitted_q;
    emit      = 1'b0;
    if (err_q == mtap_pkg::StOk) begin
      case (pos_q)
        mtap_pkg::PosLen: begin
          if (hdr_n != {16'd0, atom_length_i}) err_n = mtap_pkg::StLen;
        end
        mtap_pkg::PosTag: begin
          if (hdr_n != mtap_pkg::TagWord) err_n = mtap_pkg::StTag;
        end
        mtap_pkg::PosVer: begin
          if (sz != mtap_pkg::One16) err_n = mtap_pkg::StVer;
        end
        mtap_pkg::PosSize: begin
          wanted_n = (sz >= mtap_pkg::SizeBias) ? ((sz - mtap_pkg::SizeBias) >> 1) : 16'd0;
        end
        mtap_pkg::PosWord: begin
          if (hdr_n != mtap_pkg::One32) err_n = mtap_pkg::StWord;
        end
        mtap_pkg::PosFlag: begin
          if (sz != mtap_pkg::One16) err_n = mtap_pkg::StFlag;
        end
        default: begin
          // odd title bytes carry the low half of each character
          if (pos_q >= mtap_pkg::HdrBytes && pos_q[0] && pos_q < atom_length_i &&
              {8'd0, emitted_q} < wanted_q && emitted_q < MaxTitleC) begin
            emit      = 1'b1;
            emitted_n = emitted_q + 8'd1;
          end
        end
      endcase
    end
  end

  assign pos_inc = {1'b0, pos_q} + 17'd1;
  assign trunc   = (err_n == mtap_pkg::StOk) &&
                   (pos_inc < {1'b0, mtap_pkg::HdrBytes} ||
                    atom_length_i < mtap_pkg::HdrBytes ||
                    pos_inc < {1'b0, atom_length_i});
  assign st_done = trunc ? mtap_pkg::StTrunc : err_n;

  always_comb begin
    res_char              = '0;
    res_char.kind         = mtap_pkg::KindChar;
    res_char.char_code    = byte_value_i;
    res_char.char_index   = emitted_q;
    res_char.status       = mtap_pkg::StOk;
    res_done              = '0;
    res_done.kind         = mtap_pkg::KindDone;
    res_done.status       = st_done;
    res_done.title_length = emitted_n;
    res_done.final_res    = 1'b1;
  end

  always_comb begin
    push_o.n      = accept_i ? ({1'b0, emit} + {1'b0, is_last_i}) : 2'd0;
    push_o.first  = emit ? res_char : res_done;
    push_o.second = res_done;
  end

  always_comb begin
    pos_d     = pos_q;
    hdr_d     = hdr_q;
    wanted_d  = wanted_q;
    emitted_d = emitted_q;
    err_d     = err_q;
    if (accept_i) begin
      if (is_last_i) begin
        pos_d     = '0;
        hdr_d     = '0;
        wanted_d  = '0;
        emitted_d = '0;
        err_d     = mtap_pkg::StOk;
      end else begin
        pos_d     = (pos_q != mtap_pkg::PosMax) ? pos_inc[15:0] : pos_q;
        hdr_d     = hdr_n;
        wanted_d  = wanted_n;
        emitted_d = emitted_n;
        err_d     = err_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      hdr_q     <= '0;
      wanted_q  <= '0;
      emitted_q <= '0;
      err_q     <= mtap_pkg::StOk;
    end else begin
      pos_q     <= pos_d;
      hdr_q     <= hdr_d;
      wanted_q  <= wanted_d;
      emitted_q <= emitted_d;
      err_q     <= err_d;
    end
  end

endmodule

FILE: hdl/mtap_rq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtap_rq
// result queue, takes up to two results a cycle and gives out one
// ----------------------------------------------------------------------------
module mtap_rq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mtap_pkg::push_t     push_i,
  output logic                space_o,
  output logic                valid_o,
  input  logic                ready_i,
  output mtap_pkg::result_t   data_o
);

  mtap_pkg::result_t                  mem_q [mtap_pkg::RqDepth];
  logic [mtap_pkg::RqPtrW-1:0]        wr_q, wr_d, rd_q, rd_d, wr_nx;
  logic [mtap_pkg::RqCntW-1:0]        cnt_q, cnt_d;
  logic                               pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_q];
  // room for two more results beside the entries held now
  assign space_o = (cnt_q <= mtap_pkg::RqCntW'(mtap_pkg::RqDepth - 2));
  assign wr_nx   = wr_q + mtap_pkg::RqPtrW'(1);

  always_comb begin
    wr_d  = wr_q + mtap_pkg::RqPtrW'(push_i.n);
    rd_d  = rd_q + mtap_pkg::RqPtrW'(pop);
    cnt_d = cnt_q + mtap_pkg::RqCntW'(push_i.n) - mtap_pkg::RqCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_nx] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: hdl/metadata_title_atom_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// metadata_title_atom_parser
// checks a title atom header and gives out the title characters
// ----------------------------------------------------------------------------
// in_i carries the atom one byte per transaction with the atom length and a
// last-byte mark. out_o carries results: a title character (kind 0) for the
// low byte of each title character, and on the last byte a completion report
// (kind 1, final_res set) with the status and the title length.
// A byte is taken every cycle while the queue has room; the header check and
// the title logic sit in one combinational step ahead of a four-entry result
// queue, which registers each result when its byte is accepted and offers it
// on out_o. A byte gives at most two results (a character and the report),
// which the queue absorbs. in_i.ready drops while the queue holds more than
// two results, so a stalled receiver holds results in the queue and
// back-pressures the byte stream. Reset clears the parser state and empties
// the queue; the block is ready as soon as reset is released. After each last
// byte the state returns to its reset value for the next atom.
// ----------------------------------------------------------------------------
module metadata_title_atom_parser #(
  parameter int unsigned MAX_TITLE = 255
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  mtap_in_if.sink       in_i,
  mtap_out_if.source    out_o
);

  mtap_pkg::push_t   push;
  mtap_pkg::result_t res;
  logic              space;
  logic              accept;

  assign in_i.ready = space;
  assign accept     = in_i.valid && space;

  mtap_core #(
    .MAX_TITLE (MAX_TITLE)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .byte_value_i  (in_i.byte_value),
    .atom_length_i (in_i.atom_length),
    .is_last_i     (in_i.is_last),
    .push_o        (push)
  );

  mtap_rq u_rq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (res)
  );

  assign out_o.kind         = res.kind;
  assign out_o.char_code    = res.char_code;
  assign out_o.char_index   = res.char_index;
  assign out_o.status       = res.status;
  assign out_o.title_length = res.title_length;
  assign out_o.final_res    = res.final_res;

endmodule

FILE: hdl/mtap_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtap_port_checks
// port-level checks on the title atom parser
// ----------------------------------------------------------------------------
module mtap_port_checks (
  input logic         clk_i,
  input logic         rst_ni,
  mtap_in_if.sink     in_i,
  mtap_out_if.source  out_o
);

  // a pending result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid)
    else $error("result withdrawn before its transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=>
      $stable({out_o.kind, out_o.char_code, out_o.char_index, out_o.status,
               out_o.title_length, out_o.final_res}))
    else $error("stalled result changed");

  // an empty result side never blocks the byte stream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("input stalled with no pending result");

  // only the completion report closes an atom, and characters carry no status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.kind == out_o.final_res) &&
                    (out_o.kind || (out_o.status == mtap_pkg::StOk &&
                                    out_o.title_length == 8'd0)))
    else $error("result kind and completion fields disagree");

endmodule

bind metadata_title_atom_parser mtap_port_checks u_mtap_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_o  (out_o)
);
